>>> rtl/periodic_timer_bank_top_defines.svh
`ifndef PERIODIC_TIMER_BANK_TOP_DEFINES_SVH
`define PERIODIC_TIMER_BANK_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PTB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ptb_pkg.sv
`default_nettype none

package ptb_pkg;

  typedef enum logic [2:0] {
    FUNC_CREATE  = 3'd0,
    FUNC_DELETE  = 3'd1,
    FUNC_ENABLE  = 3'd2,
    FUNC_DISABLE = 3'd3,
    FUNC_TICK    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    KIND_CREATE    = 2'd0,
    KIND_ACK       = 2'd1,
    KIND_EXPIRY    = 2'd2,
    KIND_IDLE_TICK = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  slot_id;
    logic [15:0] interval;
    logic        has_handler;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] timer_slot;
    logic       ok;
    logic       last;
  } out_item_t;

  // scan token passed from cell to cell
  typedef struct packed {
    logic        valid;
    logic        create;
    logic        pending;
    logic        notify;
    logic [15:0] period;
  } tok_t;

  // direct command to one addressed cell
  typedef struct packed {
    logic       valid;
    func_t      func;
    logic [5:0] slot;
  } cmd_t;

  typedef struct packed {
    logic fire;
    logic claim;
  } ev_t;

endpackage

`default_nettype wire

>>> rtl/ptb_cell.sv
`default_nettype none

module ptb_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ptb_pkg::tok_t tok_in,
  output ptb_pkg::tok_t      tok_out,
  input  wire ptb_pkg::cmd_t cmd,
  output logic               used,
  output ptb_pkg::ev_t       ev
);

  ptb_pkg::tok_t tok;
  logic          enabled;
  logic          notify;
  logic [15:0]   count;
  logic [15:0]   period;

  logic          used_next;
  logic          enabled_next;
  logic          notify_next;
  logic [15:0]   count_next;
  logic [15:0]   period_next;
  logic [15:0]   count_inc;
  logic          wrap;
  logic          tick_here;
  logic          claim_here;
  logic          cmd_here;

  assign count_inc  = count + 16'd1;
  assign wrap       = (period != 16'd0) && (count_inc == (period - 16'd1));
  assign tick_here  = tok.valid && !tok.create && used && enabled;
  assign claim_here = tok.valid && tok.create && tok.pending && !used;
  assign cmd_here   = cmd.valid && (cmd.slot == 6'(CELL_IDX)) && used;

  always_comb begin
    used_next    = used;
    enabled_next = enabled;
    notify_next  = notify;
    count_next   = count;
    period_next  = period;
    ev.fire      = 1'b0;
    ev.claim     = claim_here;
    tok_out      = tok;
    tok_out.pending = tok.pending && !claim_here;
    if (tick_here) begin
      if (wrap) begin
        count_next = 16'd0;
        ev.fire    = notify;
      end else begin
        count_next = count_inc;
      end
    end
    if (claim_here) begin
      used_next    = 1'b1;
      enabled_next = 1'b0;
      notify_next  = tok.notify;
      count_next   = 16'd0;
      period_next  = tok.period;
    end
    if (cmd_here) begin
      case (cmd.func)
        ptb_pkg::FUNC_DELETE: begin
          used_next    = 1'b0;
          enabled_next = 1'b0;
          notify_next  = 1'b0;
          count_next   = 16'd0;
          period_next  = 16'd0;
        end
        ptb_pkg::FUNC_ENABLE:  enabled_next = 1'b1;
        ptb_pkg::FUNC_DISABLE: enabled_next = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok     <= '0;
      used    <= 1'b0;
      enabled <= 1'b0;
      notify  <= 1'b0;
      count   <= 16'd0;
      period  <= 16'd0;
    end else begin
      tok     <= tok_in;
      used    <= used_next;
      enabled <= enabled_next;
      notify  <= notify_next;
      count   <= count_next;
      period  <= period_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/periodic_timer_bank_top.sv
`default_nettype none

// Bank of TIMERS periodic timers, one per cell in a row. Delete, enable,
// disable and unknown commands leave busy low: the acknowledge word appears
// in the cycle after start. Create and tick launch a token that walks the
// cells one per cycle, so they hold busy until the final word is issued;
// that walk sets the rate. Tick expiries come out in rising slot order, at
// most one word per cycle, with last set on the final word. Every word is
// on result for exactly one cycle with strobe high and must be taken then:
// there is no back-pressure.
`include "periodic_timer_bank_top_defines.svh"

module periodic_timer_bank_top #(
  parameter int TIMERS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire ptb_pkg::in_item_t cmd,
  output logic                   strobe,
  output ptb_pkg::out_item_t     result
);

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  ptb_pkg::state_t    state;
  ptb_pkg::state_t    state_next;
  logic               op_create;
  logic               op_create_next;
  logic               pend_valid;
  logic               pend_valid_next;
  logic [5:0]         pend_slot;
  logic [5:0]         pend_slot_next;
  logic               emit;
  ptb_pkg::out_item_t emit_item;

  ptb_pkg::tok_t      toks [TIMERS+1];
  ptb_pkg::ev_t       evs  [TIMERS];
  ptb_pkg::cmd_t      bcast;
  logic [TIMERS-1:0]  used_vec;
  logic [TIMERS-1:0]  fire_vec;
  logic [TIMERS-1:0]  claim_vec;
  logic [5:0]         hit_slot;
  logic               accept;
  logic               in_range;
  logic               is_cmd;

  assign busy     = (state != ptb_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, cmd.slot_id} < 7'(TIMERS));
  assign is_cmd   = (cmd.func == ptb_pkg::FUNC_DELETE) ||
                    (cmd.func == ptb_pkg::FUNC_ENABLE) ||
                    (cmd.func == ptb_pkg::FUNC_DISABLE);

  always_comb begin
    bcast.valid = accept && is_cmd && in_range;
    bcast.func  = ptb_pkg::func_t'(cmd.func);
    bcast.slot  = cmd.slot_id;
  end

  genvar gi;
  generate
    for (gi = 0; gi < TIMERS; gi++) begin : g_cell
      ptb_cell #(.CELL_IDX(gi)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (toks[gi]),
        .tok_out (toks[gi+1]),
        .cmd     (bcast),
        .used    (used_vec[gi]),
        .ev      (evs[gi])
      );
      assign fire_vec[gi]  = evs[gi].fire;
      assign claim_vec[gi] = evs[gi].claim;
    end
  endgenerate

  // only the cell holding the token can report
  always_comb begin
    hit_slot = 6'd0;
    for (int i = 0; i < TIMERS; i++) begin
      if (fire_vec[i] || claim_vec[i]) begin
        hit_slot = 6'(i);
      end
    end
  end

  always_comb begin
    state_next      = state;
    op_create_next  = op_create;
    pend_valid_next = pend_valid;
    pend_slot_next  = pend_slot;
    emit            = 1'b0;
    emit_item       = '0;
    toks[0]         = '0;
    case (state)
      ptb_pkg::ST_IDLE: begin
        if (accept) begin
          if ((cmd.func == ptb_pkg::FUNC_CREATE) || (cmd.func == ptb_pkg::FUNC_TICK)) begin
            toks[0].valid   = 1'b1;
            toks[0].create  = (cmd.func == ptb_pkg::FUNC_CREATE);
            toks[0].pending = 1'b1;
            toks[0].notify  = cmd.has_handler;
            toks[0].period  = cmd.interval;
            op_create_next  = (cmd.func == ptb_pkg::FUNC_CREATE);
            pend_valid_next = 1'b0;
            state_next      = ptb_pkg::ST_SCAN;
          end else begin
            emit                 = 1'b1;
            emit_item.kind       = ptb_pkg::KIND_ACK;
            emit_item.timer_slot = cmd.slot_id;
            emit_item.ok         = is_cmd && in_range && used_vec[cmd.slot_id[IDX_W-1:0]];
            emit_item.last       = 1'b1;
          end
        end
      end
      ptb_pkg::ST_SCAN: begin
        if (op_create) begin
          if (|claim_vec) begin
            pend_valid_next = 1'b1;
            pend_slot_next  = hit_slot;
          end
        end else if (|fire_vec) begin
          // hold back one expiry so the final one can carry last
          if (pend_valid) begin
            emit                 = 1'b1;
            emit_item.kind       = ptb_pkg::KIND_EXPIRY;
            emit_item.timer_slot = pend_slot;
            emit_item.ok         = 1'b1;
            emit_item.last       = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_slot_next  = hit_slot;
        end
        if (toks[TIMERS].valid) begin
          state_next = ptb_pkg::ST_FLUSH;
        end
      end
      ptb_pkg::ST_FLUSH: begin
        emit           = 1'b1;
        emit_item.last = 1'b1;
        if (op_create) begin
          emit_item.kind       = ptb_pkg::KIND_CREATE;
          emit_item.timer_slot = pend_valid ? pend_slot : 6'd0;
          emit_item.ok         = pend_valid;
        end else if (pend_valid) begin
          emit_item.kind       = ptb_pkg::KIND_EXPIRY;
          emit_item.timer_slot = pend_slot;
          emit_item.ok         = 1'b1;
        end else begin
          emit_item.kind       = ptb_pkg::KIND_IDLE_TICK;
          emit_item.timer_slot = 6'd0;
          emit_item.ok         = 1'b0;
        end
        state_next = ptb_pkg::ST_IDLE;
      end
      default: state_next = ptb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptb_pkg::ST_IDLE;
      op_create  <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      op_create  <= op_create_next;
      pend_valid <= pend_valid_next;
      strobe     <= emit;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot <= pend_slot_next;
    result    <= emit_item;
  end

  `PTB_ASSERT_NOW(a_last_frees, strobe && result.last, !busy, "busy after final word")
  `PTB_ASSERT_NOW(a_mid_is_expiry, strobe && !result.last,
                  result.kind == ptb_pkg::KIND_EXPIRY, "non-final word is not an expiry")
  `PTB_ASSERT_NOW(a_one_reporter, 1'b1, $onehot0(fire_vec | claim_vec),
                  "more than one cell reports at once")
  `PTB_ASSERT_NOW(a_create_no_fire, state == ptb_pkg::ST_SCAN && op_create,
                  fire_vec == '0, "expiry during create scan")
  `PTB_ASSERT_NEXT(a_flush_ends, state == ptb_pkg::ST_FLUSH, strobe && result.last,
                   "scan end gave no final word")

endmodule

`default_nettype wire

>>> tb/sv/periodic_timer_bank_top_tb.sv
`default_nettype none

module periodic_timer_bank_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptb_pkg::*;

  localparam int TIMERS = 16;
  localparam int RANDOM_WORDS = 500;
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

  typedef struct packed {
    in_item_t  word;
    logic      typed;
    out_item_t want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  cmd;
  logic      strobe;
  out_item_t result;

  // shadow of the timer table
  logic        timer_used    [TIMERS];
  logic        timer_enabled [TIMERS];
  logic        timer_notify  [TIMERS];
  logic [15:0] timer_count   [TIMERS];
  logic [15:0] timer_period  [TIMERS];

  out_item_t  pending_words[$];
  out_item_t  fresh_words[$];
  plan_row_t  plan[$];
  int         errors = 0;
  int         burst_left = 0;

  periodic_timer_bank_top #(.TIMERS(TIMERS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  always #6 clk = ~clk;

  function automatic out_item_t make_word(kind_t k, int slot, logic ok, logic last);
    out_item_t o;
    o.kind       = k;
    o.timer_slot = slot[5:0];
    o.ok         = ok;
    o.last       = last;
    return o;
  endfunction

  function automatic plan_row_t step_row(logic [2:0] f, int sid, int ival, int handler,
                                         int typed, kind_t k, int tslot, int ok);
    plan_row_t r;
    r.word.func        = f;
    r.word.slot_id     = sid[5:0];
    r.word.interval    = ival[15:0];
    r.word.has_handler = handler[0];
    r.typed            = typed[0];
    r.want             = make_word(k, tslot, ok[0], 1'b1);
    return r;
  endfunction

  // computes the words one command produces and updates the shadow table
  function automatic void predict_timer_bank(in_item_t w);
    int sid;
    int hit;
    logic ok;
    out_item_t tail;
    sid = int'(w.slot_id);
    hit = -1;
    fresh_words.delete();
    case (w.func)
      FUNC_CREATE: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (hit < 0 && !timer_used[i]) hit = i;
        end
        if (hit >= 0) begin
          timer_used[hit]    = 1'b1;
          timer_enabled[hit] = 1'b0;
          timer_notify[hit]  = w.has_handler;
          timer_count[hit]   = '0;
          timer_period[hit]  = w.interval;
          fresh_words.push_back(make_word(KIND_CREATE, hit, 1'b1, 1'b1));
        end else begin
          fresh_words.push_back(make_word(KIND_CREATE, 0, 1'b0, 1'b1));
        end
      end
      FUNC_DELETE, FUNC_ENABLE, FUNC_DISABLE: begin
        ok = 1'b0;
        if (sid < TIMERS && timer_used[sid]) begin
          ok = 1'b1;
          if (w.func == FUNC_DELETE) begin
            timer_used[sid]   = 1'b0;
            timer_notify[sid] = 1'b0;
            timer_count[sid]  = '0;
            timer_period[sid] = '0;
          end
          timer_enabled[sid] = (w.func == FUNC_ENABLE);
        end
        fresh_words.push_back(make_word(KIND_ACK, sid, ok, 1'b1));
      end
      FUNC_TICK: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (timer_used[i] && timer_enabled[i]) begin
            timer_count[i] = timer_count[i] + 16'd1;
            if (timer_period[i] != 16'd0 && timer_count[i] == timer_period[i] - 16'd1) begin
              timer_count[i] = '0;
              if (timer_notify[i]) fresh_words.push_back(make_word(KIND_EXPIRY, i, 1'b1, 1'b0));
            end
          end
        end
        if (fresh_words.size() == 0) begin
          fresh_words.push_back(make_word(KIND_IDLE_TICK, 0, 1'b0, 1'b1));
        end else begin
          tail = fresh_words.pop_back();
          tail.last = 1'b1;
          fresh_words.push_back(tail);
        end
      end
      default: fresh_words.push_back(make_word(KIND_ACK, sid, 1'b0, 1'b1));
    endcase
  endfunction

  // holds start until the word is taken, then records what it should produce
  task automatic issue_word(in_item_t w, logic typed, out_item_t want);
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
    predict_timer_bank(w);
    if (typed) begin
      pending_words.push_back(want);
    end else begin
      foreach (fresh_words[i]) pending_words.push_back(fresh_words[i]);
    end
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && strobe) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result word: kind %0d slot %0d", result.kind, result.timer_slot);
        errors++;
      end else begin
        want = pending_words.pop_front();
        check_field("kind", int'(want.kind), int'(result.kind));
        check_field("timer_slot", int'(want.timer_slot), int'(result.timer_slot));
        check_field("ok", int'(want.ok), int'(result.ok));
        check_field("last", int'(want.last), int'(result.last));
      end
    end
  end

  initial begin
    in_item_t w;
    int pick;
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    for (int i = 0; i < TIMERS; i++) begin
      timer_used[i]    = 1'b0;
      timer_enabled[i] = 1'b0;
      timer_notify[i]  = 1'b0;
      timer_count[i]   = '0;
      timer_period[i]  = '0;
    end

    // empty bank, bad slots, unknown funcs
    plan.push_back(step_row(FUNC_TICK,    0, 0, 0, 1, KIND_IDLE_TICK, 0, 0));
    plan.push_back(step_row(FUNC_DELETE,  0, 0, 0, 1, KIND_ACK, 0, 0));
    plan.push_back(step_row(FUNC_ENABLE, 63, 16'hffff, 1, 1, KIND_ACK, 63, 0));
    plan.push_back(step_row(FUNC_SPARE_LAST, 42, 0, 1, 1, KIND_ACK, 42, 0));
    plan.push_back(step_row(FUNC_SPARE_FIRST, 0, 0, 0, 1, KIND_ACK, 0, 0));
    // creates fill the lowest slots: short, zero, one, max, no-handler
    plan.push_back(step_row(FUNC_CREATE, 0, 3, 1, 1, KIND_CREATE, 0, 1));
    plan.push_back(step_row(FUNC_CREATE, 0, 0, 1, 1, KIND_CREATE, 1, 1));
    plan.push_back(step_row(FUNC_CREATE, 0, 1, 1, 1, KIND_CREATE, 2, 1));
    plan.push_back(step_row(FUNC_CREATE, 63, 16'hffff, 0, 1, KIND_CREATE, 3, 1));
    plan.push_back(step_row(FUNC_CREATE, 0, 2, 0, 1, KIND_CREATE, 4, 1));
    plan.push_back(step_row(FUNC_ENABLE, 0, 0, 0, 1, KIND_ACK, 0, 1));
    plan.push_back(step_row(FUNC_ENABLE, 1, 0, 0, 1, KIND_ACK, 1, 1));
    plan.push_back(step_row(FUNC_ENABLE, 2, 0, 0, 1, KIND_ACK, 2, 1));
    plan.push_back(step_row(FUNC_ENABLE, 3, 0, 0, 1, KIND_ACK, 3, 1));
    plan.push_back(step_row(FUNC_ENABLE, 4, 0, 0, 1, KIND_ACK, 4, 1));
    plan.push_back(step_row(FUNC_TICK, 0, 0, 0, 0, KIND_ACK, 0, 0));
    plan.push_back(step_row(FUNC_TICK, 0, 0, 0, 0, KIND_ACK, 0, 0));
    plan.push_back(step_row(FUNC_DISABLE, 0, 0, 0, 1, KIND_ACK, 0, 1));
    plan.push_back(step_row(FUNC_DELETE, 4, 0, 0, 1, KIND_ACK, 4, 1));
    // freed slot is reused, then two expiries land on one tick
    plan.push_back(step_row(FUNC_CREATE, 0, 2, 1, 0, KIND_ACK, 0, 0));
    plan.push_back(step_row(FUNC_ENABLE, 4, 0, 0, 1, KIND_ACK, 4, 1));
    plan.push_back(step_row(FUNC_ENABLE, 0, 0, 0, 1, KIND_ACK, 0, 1));
    plan.push_back(step_row(FUNC_TICK, 0, 0, 0, 0, KIND_ACK, 0, 0));
    plan.push_back(step_row(FUNC_TICK, 0, 0, 0, 0, KIND_ACK, 0, 0));
    plan.push_back(step_row(FUNC_TICK, 0, 0, 0, 0, KIND_ACK, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) issue_word(plan[i].word, plan[i].typed, plan[i].want);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w.func        = FUNC_TICK;
      w.slot_id     = 6'($urandom_range(0, 63));
      w.interval    = 16'($urandom_range(0, 65535));
      w.has_handler = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        w.func = FUNC_CREATE;
        if ($urandom_range(0, 7) != 0) w.interval = 16'($urandom_range(0, 6));
        w.has_handler = ($urandom_range(0, 3) != 0);
      end else if (pick < 60) begin
        w.func = (pick < 32) ? FUNC_DELETE : (pick < 52) ? FUNC_ENABLE : FUNC_DISABLE;
        // mostly real slots, sometimes anything the field holds
        if ($urandom_range(0, 9) != 0) w.slot_id = 6'($urandom_range(0, TIMERS - 1));
      end else if (pick >= 95) begin
        w.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
      end
      issue_word(w, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (TIMERS + 8) @(posedge clk);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
